// ===== rtl/periodic_event_dispatcher_top_macros.svh =====
// assertion macros for the periodic event dispatcher checker
`ifndef PERIODIC_EVENT_DISPATCHER_TOP_MACROS_SVH
`define PERIODIC_EVENT_DISPATCHER_TOP_MACROS_SVH

// same-cycle implication under reset
`define PED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define PED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ped_pkg.sv =====
// shared types and codes for the periodic event dispatcher
package ped_pkg;

	localparam int PERIOD_W = 16;
	localparam int TICK_W   = 32;
	localparam int SLOT_W   = 6;
	localparam int STAT_W   = 2;
	localparam int NMATCH_W = 7;
	localparam int RESULT_CAP = 64;

	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_TICK     = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_INVALID  = 2'd2;

	typedef struct packed {
		logic done;
		logic zero;
	} div_stat_t;

	typedef struct packed {
		logic              kind;
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} out_item_t;

endpackage

// ===== rtl/ped_mem.sv =====
// period table storage, one write port and one registered read port
module ped_mem import ped_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [PERIOD_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [PERIOD_W-1:0] rdata
);

	logic [PERIOD_W-1:0] mem [DEPTH];
	logic [PERIOD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ped_mod_unit.sv =====
// bit-serial remainder of tick number by period, one bit per cycle
module ped_mod_unit import ped_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [TICK_W-1:0]   dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output div_stat_t           stat
);

	localparam int CNT_W = $clog2(TICK_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TICK_W-1:0]   quo_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W-1:0] rem_nx;

	always_comb begin
		trial = {rem_q, quo_q[TICK_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_nx = PERIOD_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_nx = trial[PERIOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TICK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_q << 1;
			rem_q <= rem_nx;
		end
	end

	assign stat.done = done_q;
	// a zero period never divides anything
	assign stat.zero = (rem_q == '0) && (dsr_q != '0);

endmodule

// ===== rtl/periodic_event_dispatcher_top.sv =====
// registration result leaves in the cycle after the request is taken
// a tick walks each filled slot in turn: a table read, a divider load,
// 32 single-bit remainder steps, a done flag and a match check per slot
// one request is in work at a time; a held result stalls the walk and the next request
// reset clears the fill count and all control; table contents stay undefined
module periodic_event_dispatcher_top import ped_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // period[15:0], handler_present[16], tick_number[48:17]
	input  logic [0:0]  s_axis_tuser,  // req_type[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // status[1:0], slot_index[7:2]
	output logic [0:0]  m_axis_tuser,  // result_kind[0]
	output logic        m_axis_tlast   // last_result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [TICK_W-1:0]   tick_q;
	logic                match_q;
	logic                pend_valid_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [NMATCH_W-1:0] nmatch_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                out_free;
	logic                in_fire;
	logic                in_req;
	logic [PERIOD_W-1:0] in_period;
	logic                in_hp;
	logic [TICK_W-1:0]   in_tick;
	logic                tbl_full;
	logic                reg_ok;
	logic                mem_we;
	logic                mem_re;
	logic [PERIOD_W-1:0] mem_rdata;
	logic                div_start;
	div_stat_t           div_stat;
	logic                out_load;
	out_item_t           out_next;
	logic                walk_end;

	assign in_req    = s_axis_tuser[0];
	assign in_period = s_axis_tdata[15:0];
	assign in_hp     = s_axis_tdata[16];
	assign in_tick   = s_axis_tdata[48:17];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign tbl_full = (count_q >= CW'(MAX_ENTRIES));
	assign reg_ok   = !tbl_full && (in_period != '0) && in_hp;
	assign mem_we   = in_fire && (in_req == REQ_REGISTER) && reg_ok;
	assign mem_re   = (state_q == S_READ);
	assign div_start = (state_q == S_LOAD);
	assign walk_end = ((idx_q + CW'(1)) == count_q);

	ped_mem #(
		.DEPTH(MAX_ENTRIES),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(in_period),
		.re   (mem_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(mem_rdata)
	);

	ped_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(tick_q),
		.divisor (mem_rdata),
		.stat    (div_stat)
	);

	// result selection toward the output register
	always_comb begin
		out_load = 1'b0;
		out_next = '{kind: KIND_FIRED, status: ST_ACCEPTED, slot: pend_slot_q, last: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && (in_req == REQ_REGISTER)) begin
					out_load = 1'b1;
					out_next.kind = KIND_STATUS;
					out_next.last = 1'b1;
					if (tbl_full) begin
						out_next.status = ST_FULL;
						out_next.slot   = '0;
					end else if (!reg_ok) begin
						out_next.status = ST_INVALID;
						out_next.slot   = '0;
					end else begin
						out_next.slot = SLOT_W'(count_q);
					end
				end
			end
			S_EMIT: begin
				if (match_q && pend_valid_q && (nmatch_q != NMATCH_W'(RESULT_CAP))
						&& out_free) begin
					out_load = 1'b1;
				end
			end
			S_FLUSH: begin
				if (pend_valid_q && out_free) begin
					out_load = 1'b1;
					out_next.last = 1'b1;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			nmatch_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (mem_we) begin
						count_q <= count_q + CW'(1);
					end
					if (in_fire && (in_req == REQ_TICK) && (count_q != '0)) begin
						idx_q        <= '0;
						nmatch_q     <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (match_q && (nmatch_q == NMATCH_W'(RESULT_CAP))) begin
						// cap reached, later matches are dropped
						state_q <= S_FLUSH;
					end else if (!(match_q && pend_valid_q && !out_free)) begin
						if (match_q) begin
							pend_valid_q <= 1'b1;
							nmatch_q     <= nmatch_q + NMATCH_W'(1);
						end
						if (walk_end) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
		if (in_fire) begin
			tick_q <= in_tick;
		end
		if ((state_q == S_DIV) && div_stat.done) begin
			match_q <= div_stat.zero;
		end
		if ((state_q == S_EMIT) && match_q && (nmatch_q != NMATCH_W'(RESULT_CAP))
				&& !(pend_valid_q && !out_free)) begin
			pend_slot_q <= SLOT_W'(idx_q);
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_q.slot, out_q.status};
	assign m_axis_tuser[0] = out_q.kind;
	assign m_axis_tlast    = out_q.last;

endmodule

// ===== rtl/ped_checker.sv =====
// port-level checks on the dispatcher result stream
`include "periodic_event_dispatcher_top_macros.svh"

module ped_checker import ped_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [0:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	`PED_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
	`PED_ASSERT_NOW(a_status_last, clk, arst_n, m_axis_tvalid && (m_axis_tuser[0] == KIND_STATUS), m_axis_tlast, "registration status not marked last")
	`PED_ASSERT_NOW(a_fired_status, clk, arst_n, m_axis_tvalid && (m_axis_tuser[0] == KIND_FIRED), m_axis_tdata[1:0] == ST_ACCEPTED, "fired result with nonzero status")
	`PED_ASSERT_NOW(a_reject_slot, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] != ST_ACCEPTED), (m_axis_tdata[7:2] == '0) && (m_axis_tdata[1:0] != 2'd3), "rejected request with bad slot or status")

endmodule

bind periodic_event_dispatcher_top ped_checker u_ped_checker (.*);

// ===== tb/tb_periodic_event_dispatcher_top.sv =====
// testbench for the periodic event dispatcher: table fill, tick dispatch and stream stalls
`timescale 1ns / 1ps

module tb_periodic_event_dispatcher_top;
	import ped_pkg::*;

	localparam int MAX_SLOTS      = 64;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RX_HOLD_CYCLES = 3000;
	localparam int SETTLE_CYCLES  = 2500;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;  // period[15:0], handler_present[16], tick_number[48:17]
	logic [0:0]  s_axis_tuser  = '0;  // req_type[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // status[1:0], slot_index[7:2]
	logic [0:0]  m_axis_tuser;        // result_kind[0]
	logic        m_axis_tlast;

	// mirror of the dispatcher table
	logic [PERIOD_W-1:0] period_copy [MAX_SLOTS];
	int                  filled = 0;
	out_item_t           expected_results [$];

	int  mismatches  = 0;
	int  cycle_count = 0;
	bit  idle_on     = 1'b1;
	int  rx_gap      = 0;
	bit  rx_hold_req = 1'b0;
	bit  rx_hold_on  = 1'b0;

	periodic_event_dispatcher_top #(
		.MAX_ENTRIES(MAX_SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: short random stalls, or one long hold when asked
	always @(posedge clk) begin
		if (rx_hold_on) begin
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			rx_gap <= $urandom_range(0, 4);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_on <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_on <= 1'b0;
				rx_hold_req = 1'b0;
			end
		end
	end

	// work out the results one request causes and queue them
	task automatic predict_dispatch(input logic req, input logic [PERIOD_W-1:0] per,
			input logic hp, input logic [TICK_W-1:0] tick);
		out_item_t r;
		int        n;
		n = 0;
		if (req == REQ_REGISTER) begin
			r.kind = KIND_STATUS;
			r.slot = '0;
			r.last = 1'b1;
			// full table wins over a bad period or missing handler
			if (filled >= MAX_SLOTS) begin
				r.status = ST_FULL;
			end else if (per == '0 || !hp) begin
				r.status = ST_INVALID;
			end else begin
				period_copy[filled] = per;
				r.status = ST_ACCEPTED;
				r.slot = filled[SLOT_W-1:0];
				filled++;
			end
			expected_results.push_back(r);
		end else begin
			for (int i = 0; i < filled && n < RESULT_CAP; i++) begin
				if (tick % {16'b0, period_copy[i]} == 0) begin
					r.kind = KIND_FIRED;
					r.status = ST_ACCEPTED;
					r.slot = i[SLOT_W-1:0];
					r.last = 1'b0;
					expected_results.push_back(r);
					n++;
				end
			end
			if (n > 0)
				expected_results[expected_results.size() - 1].last = 1'b1;
		end
	endtask

	task automatic send_request(input logic req, input logic [PERIOD_W-1:0] per,
			input logic hp, input logic [TICK_W-1:0] tick);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, tick, hp, per};
		s_axis_tuser  <= req;
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		predict_dispatch(req, per, hp, tick);
	endtask

	task automatic send_register(input logic [PERIOD_W-1:0] per, input logic hp);
		send_request(REQ_REGISTER, per, hp, $urandom);
	endtask

	task automatic send_tick(input logic [TICK_W-1:0] tick);
		send_request(REQ_TICK, PERIOD_W'($urandom), 1'($urandom_range(0, 1)), tick);
	endtask

	// ticks biased toward values that small periods divide
	function automatic logic [TICK_W-1:0] pick_tick();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r < 9)
			return $urandom_range(1, 720);
		else if (r < 13)
			return 32'd720720 * $urandom_range(1, 5959);
		else
			return $urandom;
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 11);
		if (r == 0)
			return '0;
		else if (r < 8)
			return PERIOD_W'($urandom_range(1, 12));
		else if (r < 10)
			return PERIOD_W'($urandom_range(13, 200));
		else
			return PERIOD_W'($urandom);
	endfunction

	task automatic send_random_item();
		if ($urandom_range(0, 9) < 4)
			send_register(pick_period(), $urandom_range(0, 9) != 0);
		else
			send_tick(pick_tick());
	endtask

	// stop offering and let every queued result come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_register(16'hFFFF, 1'b1);
		send_tick(32'd1);               // nothing divides, no result
		send_tick(32'd65535);
		send_tick(32'hFFFF_FFFF);       // 65535 divides the largest tick
		send_register(16'd0, 1'b1);
		send_register(16'd5, 1'b0);
		send_register(16'd0, 1'b0);
		send_register(16'd1, 1'b1);
		send_tick(32'd0);               // every entry fires
		send_register(16'd2, 1'b1);
		send_register(16'd3, 1'b1);
		send_register(16'h8000, 1'b1);
		send_tick(32'd6);
		send_tick(32'd32768);
		send_tick(32'd7);
		send_tick(32'hFFFF_FFFE);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_random_item();
		wait_drained();
	endtask

	task automatic test_full_table();
		while (filled < MAX_SLOTS) send_register(pick_period() | 16'd1, 1'b1);
		send_register(PERIOD_W'($urandom_range(1, 65535)), 1'b1);
		send_register(16'd0, 1'b1);     // full reported ahead of invalid
		send_register(PERIOD_W'($urandom), 1'b0);
		send_tick(32'd0);
		send_tick(pick_tick());
		wait_drained();
	endtask

	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		repeat (4) send_tick(32'd0);
		send_tick(pick_tick());
		wait_drained();
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		send_tick(32'd0);
		repeat (10) send_random_item();
		wait_drained();
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		out_item_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, %s %0d status %0d slot %0d last %0d",
						$time, "actual kind", m_axis_tuser[0], m_axis_tdata[1:0],
						m_axis_tdata[7:2], m_axis_tlast);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", int'(want.kind), int'(m_axis_tuser[0]));
					check_field("status", int'(want.status), int'(m_axis_tdata[1:0]));
					check_field("slot_index", int'(want.slot), int'(m_axis_tdata[7:2]));
					check_field("last_result", int'(want.last), int'(m_axis_tlast));
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(90);
		test_full_table();
		test_backpressure();
		test_steady_stream();
		// a tick with no match may still be walking the table
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
				$time, expected_results.size(), expected_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
